// ===== sv/dsds_pkg.sv =====
// ----------------------------------------------------------------------------
// dsds_pkg
// shared types and constants for the dual-source deadband setpoint merger
// ----------------------------------------------------------------------------
`default_nettype none

package dsds_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int MAX_POSITION = 180;

    localparam int CH_W     = 3;
    localparam int RAW_W    = 10;
    localparam int REM_W    = 16;
    localparam int POS_W    = 8;
    localparam int DB_W     = 8;
    localparam int PROD_W   = RAW_W + POS_W;
    localparam int ADDR_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RAW_FULL = 1023;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic REQ_POT    = 1'b0;
    localparam logic REQ_REMOTE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pot_level;
        logic [POS_W-1:0] remote_level;
        logic [POS_W-1:0] target_level;
        logic             last_source;
    } entry_t;

    typedef struct packed {
        logic   we;
        logic   changed;
        entry_t next;
    } upd_t;

endpackage

`default_nettype wire

// ===== sv/dsds_mem.sv =====
// ----------------------------------------------------------------------------
// dsds_mem
// per-channel state memory, one read and one write port, registered read
// with write bypass; entries read as zero until first written after reset
// ----------------------------------------------------------------------------
`default_nettype none

module dsds_mem
    import dsds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              ren,
    input  wire logic [ADDR_W-1:0] raddr,
    output entry_t                 rdata,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire entry_t            wdata
);

    entry_t                  mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    entry_t                  rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else if (valid_reg[raddr]) begin
                rdata_reg <= mem[raddr];
            end else begin
                rdata_reg <= '0;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/dsds_update.sv =====
// ----------------------------------------------------------------------------
// dsds_update
// scales the pot product, applies the deadband test and forms the new entry
// ----------------------------------------------------------------------------
`default_nettype none

module dsds_update
    import dsds_pkg::*;
(
    input  wire logic              kind,
    input  wire logic              chan_ok,
    input  wire logic [PROD_W-1:0] prod,
    input  wire logic [POS_W-1:0]  rem_pos,
    input  wire logic [DB_W-1:0]   deadband,
    input  wire entry_t            cur,
    output upd_t                   upd
);

    logic [POS_W-1:0]   q0;
    logic [RAW_W:0]     rem_sum;
    logic [POS_W-1:0]   pot_pos;
    logic [POS_W-1:0]   new_pos;
    logic [POS_W-1:0]   old_pos;
    logic [POS_W-1:0]   diff;
    logic               pass;

    // divide by 1023: q0 = prod >> 10, remainder stays below twice 1023
    assign q0      = prod[PROD_W-1:RAW_W];
    assign rem_sum = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q0);
    assign pot_pos = q0 + POS_W'(rem_sum >= (RAW_W+1)'(RAW_FULL));

    assign new_pos = (kind == REQ_REMOTE) ? rem_pos : pot_pos;
    assign old_pos = (kind == REQ_REMOTE) ? cur.remote_level : cur.pot_level;
    assign diff    = (new_pos >= old_pos) ? (new_pos - old_pos) : (old_pos - new_pos);
    assign pass    = chan_ok && (diff >= deadband);

    always_comb begin
        upd.we      = pass;
        upd.changed = pass;
        upd.next    = cur;
        if (pass) begin
            upd.next.target_level = new_pos;
            upd.next.last_source  = kind;
            if (kind == REQ_REMOTE) begin
                upd.next.remote_level = new_pos;
            end else begin
                upd.next.pot_level = new_pos;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/dual_source_deadband_setpoint.sv =====
// ----------------------------------------------------------------------------
// dual_source_deadband_setpoint
// setpoint merger for servo channels fed by pot samples and remote requests
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request per transaction: s_tuser is the request
//   kind (0 pot sample, 1 remote set), s_tdata the channel and both values.
//   m_ channel returns one result per request: s_tuser-style flag m_tuser
//   says the target was updated, m_tdata holds channel, target and source.
//   cfg_we/cfg_wdata write the deadband while no request is in flight.
// pipeline and throughput:
//   a request is accepted every cycle while the output does not stall; its
//   result passes the state memory read, then update and output register.
//   back-to-back requests to one channel are served by the memory's write
//   bypass, so one transaction per cycle is sustained while m_tready is high.
// reset and stall:
//   aresetn low clears all channel state to zero and the deadband to one.
//   when m_tready is low the output register holds and the update stage
//   stalls behind it; s_tready drops only once that stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_source_deadband_setpoint
    import dsds_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [DB_W-1:0]      cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // channel[2:0], pot_raw[12:3], remote_value[28:13], zero[31:29]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_channel[2:0], target_position[10:3], target_source[11], zero[15:12]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // changed[0]
    output logic                      m_tuser
);

    logic [DB_W-1:0]   deadband_reg;

    logic              s1_valid_reg;
    logic              s1_kind_reg;
    logic              s1_ok_reg;
    logic [CH_W-1:0]   s1_chan_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [POS_W-1:0]  s1_rem_reg;

    logic              m_valid_reg;
    logic              m_changed_reg;
    logic [CH_W-1:0]   m_chan_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic              m_src_reg;

    logic              s_accept;
    logic              s1_move;
    logic [CH_W-1:0]   in_chan;
    logic [RAW_W-1:0]  in_raw;
    logic [REM_W-1:0]  in_rem;
    logic              in_ok;
    logic [PROD_W-1:0] in_prod;
    logic [POS_W-1:0]  in_rem_pos;
    entry_t            rd_entry;
    upd_t              upd;
    logic              mem_we;

    assign in_chan = s_tdata[CH_W-1:0];
    assign in_raw  = s_tdata[CH_W+RAW_W-1:CH_W];
    assign in_rem  = s_tdata[CH_W+RAW_W+REM_W-1:CH_W+RAW_W];
    assign in_ok   = (int'(in_chan) < NUM_CHANNELS);

    assign in_prod = PROD_W'(in_raw) * PROD_W'(MAX_POSITION);

    always_comb begin
        if (in_rem[REM_W-1]) begin
            in_rem_pos = '0;
        end else if (in_rem > REM_W'(MAX_POSITION)) begin
            in_rem_pos = POS_W'(MAX_POSITION);
        end else begin
            in_rem_pos = in_rem[POS_W-1:0];
        end
    end

    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;
    assign mem_we   = s1_move && upd.we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= DB_W'(1);
        end else if (cfg_we) begin
            deadband_reg <= cfg_wdata;
        end
    end

    dsds_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ren     (s_accept && in_ok),
        .raddr   (ADDR_W'(in_chan)),
        .rdata   (rd_entry),
        .we      (mem_we),
        .waddr   (ADDR_W'(s1_chan_reg)),
        .wdata   (upd.next)
    );

    dsds_update u_update (
        .kind     (s1_kind_reg),
        .chan_ok  (s1_ok_reg),
        .prod     (s1_prod_reg),
        .rem_pos  (s1_rem_reg),
        .deadband (deadband_reg),
        .cur      (rd_entry),
        .upd      (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg <= s_tuser;
            s1_ok_reg   <= in_ok;
            s1_chan_reg <= in_chan;
            s1_prod_reg <= in_prod;
            s1_rem_reg  <= in_rem_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_changed_reg <= upd.changed;
            m_chan_reg    <= s1_chan_reg;
            m_pos_reg     <= s1_ok_reg ? upd.next.target_level : '0;
            m_src_reg     <= s1_ok_reg ? upd.next.last_source : 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_changed_reg;
    assign m_tdata  = {(M_TDATA_W-CH_W-POS_W-1)'(0), m_src_reg, m_pos_reg, m_chan_reg};

`ifndef ASSERT_OFF
    a_invalid_chan_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_move && !s1_ok_reg) |=> (!m_changed_reg && (m_pos_reg == '0) && !m_src_reg))
        else $error("invalid channel produced a nonzero result");

    a_write_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (s1_valid_reg && s1_ok_reg && upd.changed))
        else $error("state write without a completing update");

    a_move_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move |=> m_valid_reg)
        else $error("update stage moved but no result was presented");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with an empty update stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/dsds_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsds_result_checker
// watches both stream channels of the setpoint merger, keeps its own copy of
// the per-channel pot, remote and target levels plus the deadband, predicts
// one result per accepted request and compares each returned result, field
// by field, against the oldest prediction
// ----------------------------------------------------------------------------
module dsds_result_checker
    import dsds_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [DB_W-1:0]      cfg_wdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    output int                        error_count,
    output int                        pending_count,
    output int                        result_count
);

    typedef struct {
        logic             changed;
        logic [CH_W-1:0]  chan;
        logic [POS_W-1:0] pos;
        logic             src;
    } setpoint_t;

    setpoint_t        expected_setpoints[$];
    logic [POS_W-1:0] pot_lvl [NUM_CHANNELS];
    logic [POS_W-1:0] rem_lvl [NUM_CHANNELS];
    logic [POS_W-1:0] tgt_lvl [NUM_CHANNELS];
    logic             tgt_src [NUM_CHANNELS];
    logic [DB_W-1:0]  deadband;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic predict_setpoint(
        input  logic                    kind,
        input  logic [CH_W-1:0]         ch,
        input  logic [RAW_W-1:0]        raw,
        input  logic signed [REM_W-1:0] rem,
        output setpoint_t               res
    );
        int unsigned       lvl;
        int unsigned       prev;
        int unsigned       delta;
        logic [ADDR_W-1:0] idx;
        idx         = ch[ADDR_W-1:0];
        res.changed = 1'b0;
        res.chan    = ch;
        res.pos     = '0;
        res.src     = REQ_POT;
        if (ch < NUM_CHANNELS) begin
            if (kind == REQ_POT) begin
                lvl  = (raw * MAX_POSITION) / RAW_FULL;
                prev = 32'(pot_lvl[idx]);
            end else begin
                if (rem < 0) begin
                    lvl = 0;
                end else if (rem > MAX_POSITION) begin
                    lvl = MAX_POSITION;
                end else begin
                    lvl = int'(rem);
                end
                prev = 32'(rem_lvl[idx]);
            end
            delta = (lvl >= prev) ? lvl - prev : prev - lvl;
            if (delta >= deadband) begin
                if (kind == REQ_POT) begin
                    pot_lvl[idx] = lvl[POS_W-1:0];
                end else begin
                    rem_lvl[idx] = lvl[POS_W-1:0];
                end
                tgt_lvl[idx] = lvl[POS_W-1:0];
                tgt_src[idx] = kind;
                res.changed  = 1'b1;
            end
            res.pos = tgt_lvl[idx];
            res.src = tgt_src[idx];
        end
    endtask

    always @(posedge aclk) begin
        setpoint_t want;
        setpoint_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pot_lvl[i] = '0;
                rem_lvl[i] = '0;
                tgt_lvl[i] = '0;
                tgt_src[i] = REQ_POT;
            end
            deadband = 8'd1;
            expected_setpoints.delete();
        end else begin
            if (cfg_we) begin
                deadband = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                got.changed = m_tuser;
                got.chan    = m_tdata[2:0];
                got.pos     = m_tdata[10:3];
                got.src     = m_tdata[11];
                if (expected_setpoints.size() == 0) begin
                    $display("[%0t] result transaction with no request outstanding",
                             $realtime);
                    error_count++;
                end else begin
                    want = expected_setpoints.pop_front();
                    if (got.changed !== want.changed)
                        report_mismatch("changed", got.changed, want.changed);
                    if (got.chan !== want.chan)
                        report_mismatch("out_channel", got.chan, want.chan);
                    if (got.pos !== want.pos)
                        report_mismatch("target_position", got.pos, want.pos);
                    if (got.src !== want.src)
                        report_mismatch("target_source", got.src, want.src);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_setpoint(s_tuser, s_tdata[2:0], s_tdata[12:3], s_tdata[28:13], want);
                expected_setpoints.push_back(want);
            end
        end
        pending_count <= expected_setpoints.size();
    end

endmodule

// ===== tb/sv/tb_dual_source_deadband_setpoint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_source_deadband_setpoint
// drives pot samples and remote set requests into the setpoint merger under
// a series of deadband settings, with random gaps on both channels, one long
// output stall and full drains between settings; the checker predicts and
// compares every result
// ----------------------------------------------------------------------------
module tb_dual_source_deadband_setpoint;
    import dsds_pkg::*;

    localparam int ITEMS_PER_SETTING = 135;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [DB_W-1:0]      cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int chk_errors;
    int chk_pending;
    int chk_results;

    bit tx_burst;
    bit rx_burst;
    int rx_hold_cycles;
    int sent_count;
    int setting_count;
    int last_raw [8];
    int last_rem [8];

    dual_source_deadband_setpoint u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    dsds_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (chk_errors),
        .pending_count (chk_pending),
        .result_count  (chk_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_request(
        input logic       kind,
        input logic [2:0] ch,
        input logic [9:0] raw,
        input logic [15:0] rem
    );
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, rem, raw, ch};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chk_pending != 0);
    endtask

    task automatic write_deadband(input logic [DB_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        setting_count++;
    endtask

    task automatic send_random_request();
        logic       kind;
        logic [2:0] ch;
        logic [9:0] raw;
        logic [15:0] rem;
        int         mode;
        kind = 1'($urandom_range(0, 1));
        ch   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        mode = $urandom_range(0, 3);
        if (mode == 0) begin
            raw = 10'($urandom);
            rem = 16'($urandom);
        end else if (mode == 1) begin
            raw = 10'($urandom_range(0, 1023));
            rem = 16'($urandom_range(0, 260) - 40);
        end else begin
            raw = 10'(last_raw[ch] + $urandom_range(0, 60) - 30);
            rem = 16'(last_rem[ch] + $urandom_range(0, 40) - 20);
        end
        if (kind == REQ_POT) begin
            last_raw[ch] = int'(raw);
        end else if ($signed(rem) > -40 && $signed(rem) < 220) begin
            last_rem[ch] = int'($signed(rem));
        end
        send_request(kind, ch, raw, rem);
    endtask

    // receiver: random ready gaps, optional long hold-off
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [DB_W-1:0] settings [8];
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_POT;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        rx_hold_cycles = 0;
        sent_count     = 0;
        setting_count  = 0;
        for (int i = 0; i < 8; i++) begin
            last_raw[i] = 0;
            last_rem[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset deadband of one, scaling and clamping extremes
        send_request(REQ_POT,    3'd0, 10'd0,    16'd0);
        send_request(REQ_POT,    3'd0, 10'd1023, 16'hFFFF);
        send_request(REQ_POT,    3'd0, 10'd1022, 16'h0000);
        send_request(REQ_REMOTE, 3'd1, 10'h3FF,  16'h8000);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'h7FFF);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'd181);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'd180);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'hFFFF);
        send_request(REQ_REMOTE, 3'd3, 10'd0,    16'd90);
        send_request(REQ_POT,    3'd3, 10'd512,  16'd0);
        send_request(REQ_POT,    3'd2, 10'h2AA,  16'h5555);
        send_request(REQ_REMOTE, 3'd2, 10'h155,  16'h00AA);
        // channels past the last one
        send_request(REQ_POT,    3'd4, 10'd1023, 16'd0);
        send_request(REQ_REMOTE, 3'd7, 10'd0,    16'd100);
        send_request(REQ_REMOTE, 3'd5, 10'd0,    16'hFFFF);
        send_request(REQ_POT,    3'd6, 10'd0,    16'd0);
        drain_results();

        // zero deadband accepts repeats
        write_deadband(8'd0);
        send_request(REQ_POT,    3'd0, 10'd1022, 16'd0);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'd0);
        send_request(REQ_REMOTE, 3'd1, 10'd0,    16'hFF00);
        send_request(REQ_POT,    3'd4, 10'd5,    16'd0);
        drain_results();

        // widest deadband blocks every move
        write_deadband(8'd255);
        send_request(REQ_REMOTE, 3'd2, 10'd0,    16'h7FFF);
        send_request(REQ_POT,    3'd3, 10'd0,    16'd0);
        drain_results();

        settings[0] = 8'd1;
        settings[1] = 8'd0;
        settings[2] = 8'd5;
        settings[3] = 8'd255;
        settings[4] = 8'($urandom_range(2, 20));
        settings[5] = 8'd3;
        settings[6] = 8'($urandom_range(0, 255));
        settings[7] = 8'd128;
        for (int s = 0; s < 8; s++) begin
            write_deadband(settings[s]);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (n % 45 == 0) begin
                    tx_burst = ($urandom_range(0, 2) == 0);
                    rx_burst = ($urandom_range(0, 2) == 0);
                end
                if (s == 2 && n == 60) begin
                    // long output stall while requests keep coming
                    tx_burst       = 1'b1;
                    rx_hold_cycles = 300;
                end
                if (s == 2 && n == 100) begin
                    tx_burst = 1'b0;
                end
                if (s == 4 && n == 70) begin
                    drain_results();
                end
                send_random_request();
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        $display("summary: %0d requests over %0d deadband settings, %0d results checked",
                 sent_count, setting_count, chk_results);
        $display("pot and remote sources, clamp and scale extremes, unused channels covered");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
